>>> sv/uisfx_pkg.sv
// Package with payload types, effect codes and synthesis constants for the sound effect core.
`default_nettype none
package uisfx_pkg;
  typedef struct packed {
    logic       trigger;
    logic [1:0] effect;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               playing;
    logic [1:0]         current_effect;
    logic               dropped;
    logic [3:0]         queue_level;
  } out_word_t;

  localparam logic [1:0] EFF_CLICK   = 2'd0;
  localparam logic [1:0] EFF_TICK    = 2'd1;
  localparam logic [1:0] EFF_DING    = 2'd2;
  localparam logic [1:0] EFF_INVALID = 2'd3;

  localparam logic [11:0] LEN_CLICK   = 12'd192;
  localparam logic [11:0] LEN_TICK    = 12'd128;
  localparam logic [11:0] LEN_DING    = 12'd3520;
  localparam logic [11:0] DING_SWITCH = 12'd1120;
  localparam logic [23:0] ENV_ONE     = 24'h800000;
  localparam logic [23:0] DEC_CLICK   = 24'd8181492;
  localparam logic [23:0] DEC_TICK    = 24'd8046264;
  localparam logic [23:0] DEC_DING_A  = 24'd8378128;
  localparam logic [23:0] DEC_DING_B  = 24'd8382784;
  localparam logic [31:0] INC_180     = 32'd48318382;
  localparam logic [31:0] INC_2200    = 32'd590558003;
  localparam logic [31:0] INC_880     = 32'd236223201;
  localparam logic [31:0] INC_1318    = 32'd353932149;
  localparam logic [31:0] SEED_RESET  = 32'h12345678;
endpackage
`default_nettype wire

>>> sv/uisfx_sine.sv
// Registered sine lookup: phase in, Q1.15 sine out in the next cycle.
`default_nettype none
module uisfx_sine #(
  parameter int SINE_TABLE_BITS = 10
) (
  input  wire                clk,
  input  wire  [31:0]        phase,
  output logic signed [16:0] sine
);
  localparam int QB    = SINE_TABLE_BITS - 2;
  localparam int DEPTH = 1 << QB;

  // Quarter wave, first quadrant, built by the polynomial at elaboration.
  function automatic logic [15:0] quarter(input int r);
    logic [31:0] x, x2, t, y;
    begin
      x  = 32'(r) << (15 - QB);
      x2 = (x * x) >> 15;
      t  = 32'd21024 - ((x2 * 32'd2320) >> 15);
      t  = 32'd51472 - ((x2 * t) >> 15);
      y  = (x * t) >> 15;
      if (y > 32'd32767) y = 32'd32767;
      quarter = y[15:0];
    end
  endfunction

  // The mirrored quadrant needs x = 32768, which the polynomial yields and limits.
  logic [15:0] rom [DEPTH+1];
  always_comb begin
    for (int i = 0; i <= DEPTH; i++) rom[i] = quarter(i);
  end

  logic [SINE_TABLE_BITS-1:0] k;
  logic [1:0]                 quad;
  logic [QB:0]                addr;
  logic [15:0]                y;

  always_comb begin
    k    = phase[31 -: SINE_TABLE_BITS];
    quad = k[SINE_TABLE_BITS-1 -: 2];
    addr = quad[0] ? (QB+1)'(DEPTH) - {1'b0, k[QB-1:0]} : {1'b0, k[QB-1:0]};
    y    = rom[addr];
  end

  always_ff @(posedge clk) begin
    sine <= quad[1] ? -$signed({1'b0, y}) : $signed({1'b0, y});
  end
endmodule
`default_nettype wire

>>> sv/ui_sound_effect_synth_core.sv
// Top level of the UI sound effect synthesizer: queue, sequencer and shared multiplier.
//
// Usage: every input word on in_valid/in_ready is one 16 kHz sample tick carrying an
// optional play request (trigger, effect). Requests for click, tick or ding enter a
// request queue of QUEUE_DEPTH entries; invalid ids or a full queue set dropped.
// For each tick exactly one output word is produced on out_valid/out_ready, with the
// sample (0 when idle), playing, current_effect, dropped and queue_level. The user must
// write the noise seed via cfg_valid/cfg_ready/cfg_data only while idle (not enforced).
//
// Sequencing: after a tick is accepted, states run S_SIN1, S_SIN2, S_M1 to S_M6 and
// S_DONE for a click or a ding, skip S_M3 and S_M4 for a tick effect and go from
// S_SIN1 straight to S_DONE when nothing plays. One signed multiplier is shared by
// every product of a sample (envelope mix, low-pass, scaling, envelope decay),
// sequenced one product per cycle; the sine table is read one phase per cycle. The
// block accepts no new tick until the output word of the previous one has been taken,
// so it never takes a tick while it is still working on the last one.
//
// Reset clears the queue pointers, the active effect and the output handshake and
// loads the seed with 0x12345678. When the receiver stalls, the output word holds and
// in_ready stays low until it is taken. The configuration port is always ready.
`default_nettype none
module ui_sound_effect_synth_core #(
  parameter int QUEUE_DEPTH     = 8,
  parameter int SINE_TABLE_BITS = 10
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire uisfx_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output uisfx_pkg::out_word_t out_data,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire  [31:0]          cfg_data
);
  import uisfx_pkg::*;

  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SIN1, S_SIN2, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_DONE
  } state_t;

  state_t state;

  logic [1:0]     queue_mem [QUEUE_DEPTH];
  logic [QCW-1:0] count;
  logic [QAW-1:0] head;

  logic [31:0] seed;
  logic        active;
  logic [1:0]  effect;
  logic [11:0] index;
  logic [23:0] env;
  logic signed [23:0] lp;
  logic [31:0] noise;
  logic [31:0] phase;

  // Per-tick working registers.
  logic        dropped;
  logic        playing;
  logic signed [47:0] acc;
  logic signed [16:0] s1;
  logic signed [16:0] s2;
  logic signed [15:0] sample;

  // Shared multiplier: one signed 33 x 25 product per cycle.
  logic signed [32:0] ma;
  logic signed [24:0] mb;
  logic signed [57:0] prod;
  assign prod = ma * mb;

  logic [31:0] sine_phase;
  logic signed [16:0] sine;
  uisfx_sine #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_sine (
    .clk(clk), .phase(sine_phase), .sine(sine)
  );

  // Queue write position, independent of width.
  logic [QAW:0] wsum;
  logic [QAW-1:0] wptr;
  always_comb begin
    wsum = {1'b0, head} + QAW'(count);
    wptr = (wsum >= (QAW+1)'(QUEUE_DEPTH)) ? QAW'(wsum - (QAW+1)'(QUEUE_DEPTH)) : QAW'(wsum);
  end

  logic [QAW-1:0] head_inc;
  assign head_inc = (head == QAW'(QUEUE_DEPTH - 1)) ? '0 : head + QAW'(1);

  logic [31:0] s_noise;
  always_comb begin
    s_noise = noise ^ (noise << 13);
    s_noise = s_noise ^ (s_noise >> 17);
    s_noise = s_noise ^ (s_noise << 5);
  end

  logic second;
  assign second = (index >= DING_SWITCH);

  // Floor shifts of signed values are arithmetic shifts.
  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      S_M1: begin
        case (effect)
          EFF_CLICK: begin
            ma = 33'(signed'(s_noise[31:8])) - 33'(lp);
            mb = 25'sd22938;
          end
          EFF_TICK: begin
            ma = 33'(s1);
            mb = signed'({1'b0, env});
          end
          default: begin
            ma = 33'(s1);
            mb = 25'sd26214;
          end
        endcase
      end
      S_M2: begin
        case (effect)
          EFF_CLICK: begin
            ma = 33'(s1);
            mb = 25'sd13107;
          end
          EFF_TICK: begin
            ma = 33'(acc >>> 15);
            mb = 25'sd9000;
          end
          default: begin
            ma = 33'(s2);
            mb = 25'sd4915;
          end
        endcase
      end
      S_M3: begin
        ma = acc[32:0];
        mb = signed'({1'b0, env});
      end
      S_M4: begin
        ma = acc[32:0];
        mb = (effect == EFF_CLICK) ? 25'sd14000 : 25'sd12000;
      end
      S_M5: begin
        ma = signed'({9'd0, env});
        case (effect)
          EFF_CLICK: mb = signed'({1'b0, DEC_CLICK});
          EFF_TICK:  mb = signed'({1'b0, DEC_TICK});
          default:   mb = second ? signed'({1'b0, DEC_DING_B}) : signed'({1'b0, DEC_DING_A});
        endcase
      end
      default: ;
    endcase
  end

  logic signed [47:0] tq;
  always_comb begin
    tq = acc;
    if (acc < 0) tq = -((-acc) >>> 23);
    else         tq = acc >>> 23;
  end

  assign in_ready  = (state == S_IDLE) && !out_valid;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      head      <= '0;
      active    <= 1'b0;
      effect    <= EFF_CLICK;
      index     <= '0;
      env       <= '0;
      lp        <= '0;
      noise     <= SEED_RESET;
      phase     <= '0;
      seed      <= SEED_RESET;
      out_valid <= 1'b0;
      dropped   <= 1'b0;
      playing   <= 1'b0;
    end else begin
      if (cfg_valid) seed <= cfg_data;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            logic [QCW-1:0] c;
            c = count;
            dropped <= 1'b0;
            if (in_data.trigger) begin
              if (in_data.effect == EFF_INVALID || count == QCW'(QUEUE_DEPTH)) begin
                dropped <= 1'b1;
              end else begin
                queue_mem[wptr] <= in_data.effect;
                c = count + QCW'(1);
              end
            end
            playing <= active;
            if (!active && c != '0) begin
              logic [1:0] e;
              e = (in_data.trigger && count == '0 && in_data.effect != EFF_INVALID)
                  ? in_data.effect : queue_mem[head];
              if (e == EFF_INVALID) e = EFF_DING;
              effect  <= e;
              head    <= head_inc;
              c       = c - QCW'(1);
              active  <= 1'b1;
              playing <= 1'b1;
              index   <= '0;
              env     <= ENV_ONE;
              lp      <= '0;
              phase   <= '0;
              if (e == EFF_CLICK) noise <= seed;
            end
            count <= c;
            state <= S_SIN1;
          end
        end
        S_SIN1: begin
          if (!playing) begin
            sample <= '0;
            state  <= S_DONE;
          end else begin
            if (effect == EFF_DING && index == DING_SWITCH) begin
              env   <= ENV_ONE;
              phase <= 32'(DING_SWITCH) * INC_1318;
            end
            state <= S_SIN2;
          end
        end
        S_SIN2: begin
          s1    <= sine;
          state <= S_M1;
        end
        S_M1: begin
          s2 <= sine;
          if (effect == EFF_CLICK) begin
            lp    <= lp + 24'(prod >>> 16);
            noise <= s_noise;
          end
          acc   <= 48'(prod);
          state <= S_M2;
        end
        S_M2: begin
          case (effect)
            EFF_CLICK: acc <= 48'(lp) + 48'(prod >>> 7);
            EFF_TICK:  acc <= 48'(prod);
            default:   acc <= acc + 48'(prod);
          endcase
          state <= (effect == EFF_TICK) ? S_M5 : S_M3;
        end
        S_M3: begin
          acc   <= (effect == EFF_CLICK) ? 48'(prod >>> 23) : 48'(prod >>> 30);
          state <= S_M4;
        end
        S_M4: begin
          acc   <= 48'(prod);
          state <= S_M5;
        end
        S_M5: begin
          sample <= 16'(tq);
          env    <= 24'(prod >>> 23);
          state  <= S_M6;
        end
        S_M6: begin
          logic [11:0] ni;
          ni = index + 12'd1;
          case (effect)
            EFF_CLICK: phase <= phase + INC_180;
            EFF_TICK:  phase <= phase + INC_2200;
            default:   phase <= phase + (second ? INC_1318 : INC_880);
          endcase
          index <= ni;
          case (effect)
            EFF_CLICK: if (ni >= LEN_CLICK) active <= 1'b0;
            EFF_TICK:  if (ni >= LEN_TICK)  active <= 1'b0;
            default:   if (ni >= LEN_DING)  active <= 1'b0;
          endcase
          state <= S_DONE;
        end
        S_DONE: begin
          out_data.sample         <= sample;
          out_data.playing        <= playing;
          out_data.current_effect <= playing ? effect : EFF_CLICK;
          out_data.dropped        <= dropped;
          out_data.queue_level    <= 4'(count);
          out_valid               <= 1'b1;
          state                   <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Phase fed to the table: base phase in S_SIN1, doubled phase in S_SIN2. On the
  // first sample of the second ding tone the reloaded phase is looked up directly,
  // since the phase register only takes it at the end of S_SIN1.
  always_comb begin
    if (state == S_SIN2) begin
      sine_phase = phase << 1;
    end else if (state == S_SIN1 && effect == EFF_DING && index == DING_SWITCH) begin
      sine_phase = 32'(DING_SWITCH) * INC_1318;
    end else begin
      sine_phase = phase;
    end
  end
endmodule
`default_nettype wire
